### design/ghash_pkg.sv
`timescale 1ns / 1ps

package ghash_pkg;

    // GCM reduction constant (x^128 + x^7 + x^2 + x + 1, bit-reflected form)
    localparam logic [63:0] GF_POLY = 64'hc200000000000000;

    // Configuration register indices
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam int unsigned DIGIT_W    = 32;
    localparam int unsigned BLOCK_BYTES = 16;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  byte_count;
        logic        first;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } t_out_beat;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // input beat accepted this cycle
        logic       mul_step;  // fold one key digit into the product
        logic [1:0] digit;     // digit step, 0 = most significant
        logic       reduce;    // reduce product into the accumulator
        logic       out_load;  // copy accumulator into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic absorb;          // offered beat carries data (count non-zero)
    } t_dp_status;

    // Leading-byte mask; counts above sixteen keep the whole block.
    function automatic logic [127:0] byte_mask(input logic [4:0] n);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            m[127 - 8*i -: 8] = (n > 5'(i)) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    // 128 x 32 carry-less product
    function automatic logic [159:0] clmul_128x32(input logic [127:0] a,
                                                  input logic [31:0]  b);
        logic [159:0] r;
        r = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            if (b[i]) begin
                r = r ^ ({32'b0, a} << i);
            end
        end
        return r;
    endfunction

    // Two-step fold of a 256-bit product by the 0xc2 polynomial
    function automatic logic [127:0] gf_reduce(input logic [255:0] z);
        logic [63:0] lol, loh, hil, hih;
        logic [63:0] rl, rh, sl, sh;
        lol = z[63:0];
        loh = z[127:64];
        hil = z[191:128];
        hih = z[255:192];
        rl  = (lol << 63) ^ (lol << 62) ^ (lol << 57);
        rh  = (lol >> 1) ^ (lol >> 2) ^ (lol >> 7);
        loh = loh ^ rl;
        hih = hih ^ loh;
        hil = hil ^ lol ^ rh;
        sl  = (loh << 63) ^ (loh << 62) ^ (loh << 57);
        sh  = (loh >> 1) ^ (loh >> 2) ^ (loh >> 7);
        return {hih ^ sh, hil ^ sl};
    endfunction

endpackage

### design/ghash_gf128_accumulator.sv
`timescale 1ns / 1ps

// GHASH accumulator over GF(2^128) with the GCM 0xc2 reduction.
// Config: write i_cfg_wdata to key_high (index 0) or key_low (index 1) with
//   i_cfg_wr_en; only while no beat is in flight. The doubled key is derived
//   from these registers on the fly; a key write leaves the accumulator alone.
// Input channel (valid/ready): one beat per 128-bit big-endian block, with a
//   valid byte count (0 = report only, >16 = whole block) and a first flag
//   that clears the accumulator before the beat.
// Output channel (valid/ready): one digest beat per input beat, the running
//   accumulator after that beat.
// Flow: an absorbing beat passes through the multiplier (one 32-bit key digit
//   per cycle against the 128-bit sum), then reduction, then the output-load
//   step; a report-only beat goes from acceptance straight to output-load.
//   Input ready is high only in idle, so the next beat is taken only once the
//   previous one has been loaded into the output register.
// Stall: the output register holds its beat until taken; a finished item
//   waits in the output-load step and input ready stays low meanwhile.
// Reset: key, accumulator and all control state clear; no output beat.

module ghash_gf128_accumulator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_index,
    input  logic [63:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ghash_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ghash_pkg::t_out_beat o_out_data
);

    ghash_pkg::t_dp_cmd    cmd;
    ghash_pkg::t_dp_status status;

    ghash_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    ghash_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

### design/ghash_dp.sv
`timescale 1ns / 1ps

module ghash_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_index,
    input  logic [63:0]           i_cfg_wdata,
    input  ghash_pkg::t_in_beat   i_in_data,
    input  ghash_pkg::t_dp_cmd    i_cmd,
    output ghash_pkg::t_dp_status o_status,
    output ghash_pkg::t_out_beat  o_out_data
);

    logic [63:0]  r_key_high, r_key_low;
    logic [127:0] r_acc;
    logic [127:0] r_p;
    logic [255:0] r_z;
    logic [127:0] r_out;

    logic         key_msb;
    logic [127:0] key_dbl;
    logic [31:0]  key_digit;
    logic [1:0]   digit_sel;
    logic [159:0] part;
    logic [127:0] blk_masked;

    // doubled key: rotate left, fold polynomial in when top bit drops out
    assign key_msb = r_key_high[63];
    assign key_dbl = {{r_key_high[62:0], r_key_low[63]} ^ (key_msb ? ghash_pkg::GF_POLY : 64'b0),
                      {r_key_low[62:0], key_msb}};

    assign digit_sel  = ~i_cmd.digit;
    assign key_digit  = key_dbl[32*digit_sel +: 32];
    assign part       = ghash_pkg::clmul_128x32(r_p, key_digit);
    assign blk_masked = {i_in_data.block_high, i_in_data.block_low}
                        & ghash_pkg::byte_mask(i_in_data.byte_count);

    assign o_status.absorb = (i_in_data.byte_count != 5'd0);
    assign o_out_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_acc      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == ghash_pkg::CFG_KEY_HIGH) begin
                    r_key_high <= i_cfg_wdata;
                end else begin
                    r_key_low <= i_cfg_wdata;
                end
            end
            if (i_cmd.load && i_in_data.first) begin
                r_acc <= '0;
            end else if (i_cmd.reduce) begin
                r_acc <= ghash_pkg::gf_reduce(r_z);
            end
        end
    end

    // Horner over key digits, most significant first
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p <= blk_masked ^ (i_in_data.first ? 128'b0 : r_acc);
            r_z <= '0;
        end else if (i_cmd.mul_step) begin
            r_z <= {r_z[223:0], 32'b0} ^ {96'b0, part};
        end
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

endmodule

### design/ghash_ctrl.sv
`timescale 1ns / 1ps

module ghash_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ghash_pkg::t_dp_cmd    o_cmd,
    input  ghash_pkg::t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_RED,
        S_OUT
    } t_state;

    t_state     r_state;
    logic [1:0] r_cnt;
    logic       r_out_valid;
    logic       accept;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept;
        o_cmd.mul_step = (r_state == S_MUL);
        o_cmd.digit    = r_cnt;
        o_cmd.reduce   = (r_state == S_RED);
        o_cmd.out_load = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cnt   <= '0;
                        r_state <= i_status.absorb ? S_MUL : S_OUT;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_absorb_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.absorb) |=> (r_state == S_MUL && r_cnt == 2'd0))
        else $error("absorbing beat did not start the multiply");

    a_mul_then_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_cnt == 2'd3) |=> (r_state == S_RED))
        else $error("reduction did not follow the last digit");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.out_load)
        else $error("held result overwritten");

    a_idle_only_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!o_cmd.mul_step && !o_cmd.reduce && !o_cmd.out_load))
        else $error("load issued while busy");

endmodule

### tb/sv/tb_ghash_gf128_accumulator.sv
`timescale 1ns / 1ps

module tb_ghash_gf128_accumulator;

    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES     = 20;
    localparam int unsigned CFG_SETTLE       = 12;
    localparam int          PHASE_COUNT      = 8;
    localparam int unsigned RANDOM_PER_PHASE = 175;
    localparam logic [63:0] ALL_ONES         = 64'hffff_ffff_ffff_ffff;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic                 i_cfg_index = ghash_pkg::CFG_KEY_HIGH;
    logic [63:0]          i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    ghash_pkg::t_in_beat  i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    ghash_pkg::t_out_beat o_out_data;

    // Hash state as the testbench sees it
    logic [63:0]  key_hi_model  = '0;
    logic [63:0]  key_lo_model  = '0;
    logic [127:0] acc_model     = '0;

    ghash_pkg::t_in_beat  block_queue[$];      // beats waiting for the driver
    ghash_pkg::t_out_beat pending_digests[$];  // digests owed by the block, oldest first

    int unsigned  src_idle_pct   = 0;
    int unsigned  snk_stall_pct  = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  quiet_cycles   = 0;
    bit           in_fire        = 1'b0;

    ghash_gf128_accumulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // 64 x 64 carry-less product
    function automatic logic [127:0] clmul64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            if (b[i]) begin
                r = r ^ ({64'b0, a} << i);
            end
        end
        return r;
    endfunction

    // Sum times doubled key, folded back to 128 bits with the 0xc2 polynomial
    function automatic logic [127:0] ghash_mul(input logic [127:0] x,
                                               input logic [63:0]  kh_in,
                                               input logic [63:0]  kl_in);
        logic [63:0]  kh, kl, lol, loh, hil, hih;
        logic [127:0] t0, t1, t2, t3, mid, r, s;
        // doubled key: rotate left one bit, fold in the polynomial on carry-out
        kh = {kh_in[62:0], kl_in[63]};
        kl = {kl_in[62:0], kh_in[63]};
        if (kh_in[63]) begin
            kh = kh ^ ghash_pkg::GF_POLY;
        end
        t0  = clmul64(x[63:0],   kl);
        t1  = clmul64(x[63:0],   kh);
        t2  = clmul64(x[127:64], kl);
        t3  = clmul64(x[127:64], kh);
        mid = t1 ^ t2;
        lol = t0[63:0];
        loh = t0[127:64] ^ mid[63:0];
        hil = t3[63:0] ^ mid[127:64];
        hih = t3[127:64];
        r   = clmul64(lol, ghash_pkg::GF_POLY);
        loh = loh ^ r[63:0];
        hih = hih ^ loh;
        hil = hil ^ lol ^ r[127:64];
        s   = clmul64(loh, ghash_pkg::GF_POLY);
        return {hih ^ s[127:64], hil ^ s[63:0]};
    endfunction

    // Keep the leading bytes only; counts beyond sixteen take the lot
    function automatic logic [127:0] padded_block(input ghash_pkg::t_in_beat b);
        int unsigned n;
        n = (b.byte_count > 5'd16) ? 16 : int'(b.byte_count);
        return {b.block_high, b.block_low} & (~128'd0 << (8 * (16 - n)));
    endfunction

    // ------------------------------------------------------------------
    // Driver: valid held with payload until taken; ready toggled freely
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!(i_in_valid && !in_fire)) begin
            if (block_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= block_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input beat, check on output beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        ghash_pkg::t_out_beat want;
        in_fire = 1'b0;
        if (i_rst_n) begin
            in_fire = i_in_valid && o_in_ready;
            if (in_fire) begin
                if (i_in_data.first) begin
                    acc_model = '0;
                end
                // count of zero just reports what is there
                if (i_in_data.byte_count != 5'd0) begin
                    acc_model = ghash_mul(acc_model ^ padded_block(i_in_data),
                                          key_hi_model, key_lo_model);
                end
                want.digest_high = acc_model[127:64];
                want.digest_low  = acc_model[63:0];
                pending_digests.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_digests.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected digest beat, expected none, got %h_%h",
                             $time, o_out_data.digest_high, o_out_data.digest_low);
                end else begin
                    want = pending_digests.pop_front();
                    if (o_out_data.digest_high !== want.digest_high) begin
                        mismatch_count++;
                        $display("%0t: digest_high mismatch, expected %h, got %h",
                                 $time, want.digest_high, o_out_data.digest_high);
                    end
                    if (o_out_data.digest_low !== want.digest_low) begin
                        mismatch_count++;
                        $display("%0t: digest_low mismatch, expected %h, got %h",
                                 $time, want.digest_low, o_out_data.digest_low);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_block(input logic fst, input logic [4:0] cnt,
                               input logic [63:0] hi, input logic [63:0] lo);
        ghash_pkg::t_in_beat b;
        b.block_high = hi;
        b.block_low  = lo;
        b.byte_count = cnt;
        b.first      = fst;
        block_queue.push_back(b);
    endtask

    // Key registers only change with nothing in flight
    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= ghash_pkg::CFG_KEY_HIGH;
        i_cfg_wdata <= hi;
        @(negedge i_clk);
        i_cfg_index <= ghash_pkg::CFG_KEY_LOW;
        i_cfg_wdata <= lo;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        key_hi_model = hi;
        key_lo_model = lo;
    endtask

    task automatic wait_drained();
        while (block_queue.size() != 0 || pending_digests.size() != 0 || i_in_valid) begin
            @(negedge i_clk);
        end
    endtask

    task automatic queue_directed();
        queue_block(1'b1, 5'd0,  rand64(), rand64());   // clear, report only: zero
        queue_block(1'b0, 5'd16, ALL_ONES, ALL_ONES);
        queue_block(1'b0, 5'd16, '0,       '0);
        queue_block(1'b0, 5'd1,  ALL_ONES, ALL_ONES);
        queue_block(1'b0, 5'd7,  ALL_ONES, ALL_ONES);
        queue_block(1'b0, 5'd8,  ALL_ONES, ALL_ONES);
        queue_block(1'b0, 5'd9,  ALL_ONES, ALL_ONES);
        queue_block(1'b0, 5'd15, ALL_ONES, ALL_ONES);
        queue_block(1'b0, 5'd0,  rand64(), rand64());   // report as it stands
        queue_block(1'b0, 5'd17, rand64(), rand64());   // beyond sixteen
        queue_block(1'b0, 5'd31, rand64(), rand64());
        queue_block(1'b1, 5'd16, ALL_ONES, '0);
        queue_block(1'b0, 5'd16, '0,       ALL_ONES);
        queue_block(1'b1, 5'd0,  ALL_ONES, ALL_ONES);   // clear after data
        queue_block(1'b0, 5'd0,  rand64(), rand64());
        queue_block(1'b0, 5'd5,  rand64(), rand64());
        queue_block(1'b1, 5'd3,  rand64(), rand64());
        queue_block(1'b1, 5'd24, rand64(), rand64());
        queue_block(1'b0, 5'd12, rand64(), rand64());
    endtask

    // Mostly whole messages (clear, full blocks, ragged tail), some noise
    task automatic queue_random(input int unsigned target);
        int unsigned added;
        int unsigned len;
        logic [4:0]  cnt;
        logic        fst;
        added = 0;
        while (added < target) begin
            if ($urandom_range(99) < 80) begin
                len = $urandom_range(1, 8);
                for (int unsigned k = 0; k < len; k++) begin
                    cnt = (k == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16;
                    fst = (k == 0) ? ($urandom_range(9) != 0) : 1'b0;
                    queue_block(fst, cnt, rand64(), rand64());
                end
                added += len;
            end else begin
                queue_block(1'($urandom_range(1)), 5'($urandom_range(31)), rand64(), rand64());
                added++;
            end
        end
    endtask

    initial begin
        logic [63:0] key_hi_set[PHASE_COUNT];
        logic [63:0] key_lo_set[PHASE_COUNT];

        key_hi_set[0] = rand64() | 64'h8000_0000_0000_0000;  key_lo_set[0] = rand64();
        key_hi_set[1] = '0;                                   key_lo_set[1] = '0;
        key_hi_set[2] = ALL_ONES;                             key_lo_set[2] = ALL_ONES;
        key_hi_set[3] = 64'h8000_0000_0000_0000;              key_lo_set[3] = '0;
        key_hi_set[4] = '0;                                   key_lo_set[4] = 64'd1;
        key_hi_set[5] = rand64();                             key_lo_set[5] = rand64();
        key_hi_set[6] = rand64() | 64'h8000_0000_0000_0000;  key_lo_set[6] = rand64();
        key_hi_set[7] = rand64() & 64'h7fff_ffff_ffff_ffff;  key_lo_set[7] = ALL_ONES;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Each phase: new key (accumulator carries over), new idling pattern
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            repeat (CFG_SETTLE) @(negedge i_clk);
            write_key(key_hi_set[p], key_lo_set[p]);
            unique case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
                default: begin src_idle_pct = 29; snk_stall_pct = 29; end
            endcase
            if (p == 0) begin
                queue_directed();
            end
            queue_random(RANDOM_PER_PHASE);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_digests.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
